[rtl/lrs_pkg.sv]
// Package for the launcher reload sequencer: types, register indexes and the arrival check.
package lrs_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_PULL_TRAVEL   = 3'd0;
  localparam logic [2:0] REG_PULL_ORIGIN   = 3'd1;
  localparam logic [2:0] REG_LOADER_ORIGIN = 3'd2;
  localparam logic [2:0] REG_HOME_POS      = 3'd3;
  localparam logic [2:0] REG_SECOND_PICK   = 3'd4;
  localparam logic [2:0] REG_THIRD_PICK    = 3'd5;
  localparam logic [2:0] REG_HOLD_TICKS    = 3'd6;
  localparam logic [2:0] REG_TOLERANCE     = 3'd7;

  localparam logic [15:0] TOLERANCE_RESET = 16'd1000;

  // Stage bits: bit0 single move home, bit1 second dart, bit2 third dart
  localparam logic [2:0] STAGES_ALL = 3'b111;

  typedef struct packed {
    logic signed [31:0] pull_travel;
    logic signed [31:0] pull_origin;
    logic signed [31:0] loader_origin;
    logic signed [31:0] home_position;
    logic signed [31:0] second_pickup_position;
    logic signed [31:0] third_pickup_position;
    logic        [15:0] putter_hold_ticks;
    logic        [15:0] arrive_tolerance;
  } cfg_t;

  typedef struct packed {
    logic               launched;
    logic signed [31:0] pull_position;
    logic signed [15:0] pull_speed;
    logic signed [31:0] loader_position;
  } item_t;

  typedef struct packed {
    logic               pull_drive;
    logic signed [31:0] pull_target;
    logic               loader_drive;
    logic signed [31:0] loader_target;
    logic               putter_drive;
    logic               putter_up;
    logic               busy_res;
  } result_t;

  typedef struct packed {
    logic        launch_pending;
    logic        pulling;
    logic        returning;
    logic        reload_active;
    logic [2:0]  stage_pending;
    logic [1:0]  pickup_reached;
    logic [15:0] hold_count;
  } state_t;

  // |act - (org + pos)| <= tol, in 34 bits so nothing overflows
  function automatic logic arrived(input logic signed [31:0] act,
                                   input logic signed [31:0] org,
                                   input logic signed [31:0] pos,
                                   input logic [15:0] tol);
    logic signed [33:0] diff;
    logic        [33:0] mag;
    diff = $signed({{2{act[31]}}, act}) - $signed({{2{org[31]}}, org})
         - $signed({{2{pos[31]}}, pos});
    mag  = diff[33] ? 34'(-diff) : 34'(diff);
    return mag <= {18'd0, tol};
  endfunction

endpackage

[rtl/lrs_if.sv]
// Valid/ready channel interfaces for input ticks and result beats.
interface lrs_in_if;
  logic               valid;
  logic               ready;
  logic               launched;
  logic signed [31:0] pull_position;
  logic signed [15:0] pull_speed;
  logic signed [31:0] loader_position;

  modport source (output valid, launched, pull_position, pull_speed, loader_position,
                  input ready);
  modport sink (input valid, launched, pull_position, pull_speed, loader_position,
                output ready);
endinterface

interface lrs_out_if;
  logic               valid;
  logic               ready;
  logic               pull_drive;
  logic signed [31:0] pull_target;
  logic               loader_drive;
  logic signed [31:0] loader_target;
  logic               putter_drive;
  logic               putter_up;
  logic               busy_res;

  modport source (output valid, pull_drive, pull_target, loader_drive, loader_target,
                  putter_drive, putter_up, busy_res, input ready);
  modport sink (input valid, pull_drive, pull_target, loader_drive, loader_target,
                putter_drive, putter_up, busy_res, output ready);
endinterface

[rtl/lrs_step.sv]
// One control tick of the sequencer: next state and result from current state and input.
module lrs_step (
  input  lrs_pkg::state_t  st,
  input  lrs_pkg::cfg_t    cfg,
  input  lrs_pkg::item_t   item,
  output lrs_pkg::state_t  st_nxt,
  output lrs_pkg::result_t res
);

  logic               pull_arr;
  logic               home_arr;
  logic               pick_arr;
  logic               second;
  logic signed [31:0] pick_pos;

  // Arrival checks, all three in parallel
  assign second   = st.stage_pending[1];
  assign pick_pos = second ? cfg.second_pickup_position : cfg.third_pickup_position;
  assign pull_arr = lrs_pkg::arrived(item.pull_position, cfg.pull_origin,
                                     cfg.pull_travel, cfg.arrive_tolerance);
  assign home_arr = lrs_pkg::arrived(item.loader_position, cfg.loader_origin,
                                     cfg.home_position, cfg.arrive_tolerance);
  assign pick_arr = lrs_pkg::arrived(item.loader_position, cfg.loader_origin,
                                     pick_pos, cfg.arrive_tolerance);

  always_comb begin
    st_nxt = st;
    res    = '0;

    // Launch, then pull step
    if (item.launched) st_nxt.launch_pending = 1'b1;
    if (st_nxt.launch_pending) begin
      if (st.pulling) begin
        res.pull_drive  = 1'b1;
        res.pull_target = cfg.pull_travel;
        if (item.pull_speed == 16'sd0) begin
          st_nxt.pulling       = 1'b0;
          st_nxt.returning     = 1'b1;
          st_nxt.reload_active = 1'b1;
        end
      end else if (st.returning) begin
        res.pull_drive = 1'b1;
        if (pull_arr) begin
          st_nxt.pulling        = 1'b1;
          st_nxt.returning      = 1'b0;
          st_nxt.launch_pending = 1'b0;
        end
      end
    end

    // Reload step, runs in the same tick it is armed
    if (st_nxt.reload_active) begin
      if (st.stage_pending[0]) begin
        res.loader_drive  = 1'b1;
        res.loader_target = cfg.home_position;
        if (home_arr) begin
          st_nxt.stage_pending[0] = 1'b0;
          st_nxt.reload_active    = 1'b0;
        end
      end else if (st.stage_pending[2:1] != 2'b00) begin
        if (!(second ? st.pickup_reached[0] : st.pickup_reached[1])) begin
          res.loader_drive  = 1'b1;
          res.loader_target = pick_pos;
          if (pick_arr) begin
            if (second) st_nxt.pickup_reached[0] = 1'b1;
            else        st_nxt.pickup_reached[1] = 1'b1;
          end
        end else if (st.hold_count < cfg.putter_hold_ticks) begin
          // putter down, counter stops at the hold length
          st_nxt.hold_count = st.hold_count + 16'd1;
          res.putter_drive  = 1'b1;
        end else begin
          res.loader_drive  = 1'b1;
          res.loader_target = cfg.home_position;
          res.putter_drive  = 1'b1;
          res.putter_up     = 1'b1;
          if (home_arr) begin
            if (second) st_nxt.stage_pending[1] = 1'b0;
            else        st_nxt.stage_pending[2] = 1'b0;
            st_nxt.reload_active = 1'b0;
            st_nxt.hold_count    = 16'd0;
          end
        end
      end
    end

    res.busy_res = st_nxt.launch_pending | st_nxt.reload_active;
  end

endmodule

[rtl/launcher_reload_sequencer_core.sv]
// Top level of the launcher reload sequencer: channel registers, state and configuration.
//
// Usage: each beat on in_ch is one control tick (launch pulse, pull and loader
// positions, pull speed). Each accepted tick yields exactly one beat on out_ch
// with the pull and loader targets, the putter command and the busy flag.
// Configuration registers are written through cfg_we/cfg_idx/cfg_wdata while
// the block is idle; writes take effect at the next edge, no read-back.
// An accepted tick is held in the input register, then its result goes into the
// result register and is offered as a beat on out_ch once out_ch is not stalled.
// Throughput: one tick per cycle while out_ch is not stalled; the tick logic is a single pass between
// the input register and the result register.
// Stall: while out_ch.ready is low the result holds, and one more tick can
// still be taken into the input register before in_ch.ready drops.
// Reset (rst_n low, synchronous): both channel registers empty, sequencer
// back to pulling with all three reload stages pending, registers to their
// reset values (tolerance 1000, all others 0).
module launcher_reload_sequencer_core (
  input  logic        clk,
  input  logic        rst_n,
  lrs_in_if.sink      in_ch,
  lrs_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [31:0] cfg_wdata
);

  logic              in_valid_r;
  lrs_pkg::item_t    item_r;
  logic              out_valid_r;
  lrs_pkg::result_t  res_r;
  lrs_pkg::result_t  res_nxt;
  lrs_pkg::state_t   st_r;
  lrs_pkg::state_t   st_nxt;
  lrs_pkg::cfg_t     cfg_r;
  logic              adv;
  logic              in_take;

  // Handshake: the input register moves on when the result register frees up
  assign adv         = in_valid_r & (~out_valid_r | out_ch.ready);
  assign in_ch.ready = ~in_valid_r | adv;
  assign in_take     = in_ch.valid & in_ch.ready;

  lrs_step u_step (
    .st     (st_r),
    .cfg    (cfg_r),
    .item   (item_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  // Control state, sequencer state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r          <= 1'b0;
      out_valid_r         <= 1'b0;
      st_r.launch_pending <= 1'b0;
      st_r.pulling        <= 1'b1;
      st_r.returning      <= 1'b0;
      st_r.reload_active  <= 1'b0;
      st_r.stage_pending  <= lrs_pkg::STAGES_ALL;
      st_r.pickup_reached <= 2'b00;
      st_r.hold_count     <= 16'd0;
      cfg_r.pull_travel            <= 32'sd0;
      cfg_r.pull_origin            <= 32'sd0;
      cfg_r.loader_origin          <= 32'sd0;
      cfg_r.home_position          <= 32'sd0;
      cfg_r.second_pickup_position <= 32'sd0;
      cfg_r.third_pickup_position  <= 32'sd0;
      cfg_r.putter_hold_ticks      <= 16'd0;
      cfg_r.arrive_tolerance       <= lrs_pkg::TOLERANCE_RESET;
    end else begin
      if (in_take)  in_valid_r <= 1'b1;
      else if (adv) in_valid_r <= 1'b0;

      if (adv) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_we) begin
        unique case (cfg_idx)
          lrs_pkg::REG_PULL_TRAVEL:   cfg_r.pull_travel            <= cfg_wdata;
          lrs_pkg::REG_PULL_ORIGIN:   cfg_r.pull_origin            <= cfg_wdata;
          lrs_pkg::REG_LOADER_ORIGIN: cfg_r.loader_origin          <= cfg_wdata;
          lrs_pkg::REG_HOME_POS:      cfg_r.home_position          <= cfg_wdata;
          lrs_pkg::REG_SECOND_PICK:   cfg_r.second_pickup_position <= cfg_wdata;
          lrs_pkg::REG_THIRD_PICK:    cfg_r.third_pickup_position  <= cfg_wdata;
          lrs_pkg::REG_HOLD_TICKS:    cfg_r.putter_hold_ticks      <= cfg_wdata[15:0];
          lrs_pkg::REG_TOLERANCE:     cfg_r.arrive_tolerance       <= cfg_wdata[15:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.launched        <= in_ch.launched;
      item_r.pull_position   <= in_ch.pull_position;
      item_r.pull_speed      <= in_ch.pull_speed;
      item_r.loader_position <= in_ch.loader_position;
    end
    if (adv) res_r <= res_nxt;
  end

  // Result beat
  assign out_ch.valid         = out_valid_r;
  assign out_ch.pull_drive    = res_r.pull_drive;
  assign out_ch.pull_target   = res_r.pull_target;
  assign out_ch.loader_drive  = res_r.loader_drive;
  assign out_ch.loader_target = res_r.loader_target;
  assign out_ch.putter_drive  = res_r.putter_drive;
  assign out_ch.putter_up     = res_r.putter_up;
  assign out_ch.busy_res      = res_r.busy_res;

endmodule

[rtl/lrs_checker.sv]
// Port-level checker for the sequencer result channel, bound to the top level.
module lrs_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic               pull_drive,
  input logic signed [31:0] pull_target,
  input logic               loader_drive,
  input logic signed [31:0] loader_target,
  input logic               putter_drive,
  input logic               putter_up
);

  // A stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // Undriven pull target reads zero
  a_pull_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !pull_drive |-> pull_target == 32'sd0)
    else $error("pull target set without pull drive");

  // Undriven loader target reads zero
  a_loader_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !loader_drive |-> loader_target == 32'sd0)
    else $error("loader target set without loader drive");

  // Putter up only comes with a putter command and a move home
  a_putter_up: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && putter_up |-> putter_drive && loader_drive)
    else $error("putter up without command or loader move");

  // While the putter is held down the loader is not moved
  a_hold_still: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && putter_drive && !putter_up |-> !loader_drive)
    else $error("loader moved while putter held down");

endmodule

bind launcher_reload_sequencer_core lrs_checker u_lrs_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .pull_drive    (out_ch.pull_drive),
  .pull_target   (out_ch.pull_target),
  .loader_drive  (out_ch.loader_drive),
  .loader_target (out_ch.loader_target),
  .putter_drive  (out_ch.putter_drive),
  .putter_up     (out_ch.putter_up)
);

[tb/lrs_tick_checker.sv]
// Checker for the launcher reload sequencer: shadows the sequencer, predicts each result beat and compares.
`timescale 1ns / 1ps

module lrs_tick_checker
  import lrs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  lrs_in_if           in_ch,
  lrs_out_if          out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [31:0] cfg_wdata,
  output int          fail_count,
  output int          outstanding
);

  // Shadow configuration and sequencer state
  cfg_t        regs;
  logic        launch_due;
  logic        pull_phase;
  logic        return_phase;
  logic        reload_on;
  logic [2:0]  stages_left;
  logic [1:0]  picked;
  logic [15:0] hold_cnt;

  // Beats predicted but not yet seen on the result channel
  result_t results_due[$];

  // Within tolerance of origin + position; 64-bit math so nothing wraps
  function automatic logic at_spot(input logic signed [31:0] meas,
                                   input logic signed [31:0] org,
                                   input logic signed [31:0] pos);
    longint gap;
    gap = longint'(meas) - longint'(org) - longint'(pos);
    if (gap < 0) gap = -gap;
    return gap <= longint'({16'd0, regs.arrive_tolerance});
  endfunction

  // One control tick: launch, then pull step, then reload step, then busy
  function automatic result_t advance_tick(input item_t t);
    result_t r;
    logic [2:0] stage_bit;
    logic [1:0] pick_bit;
    logic signed [31:0] pick_pos;
    r = '0;
    if (t.launched) launch_due = 1'b1;

    if (launch_due) begin
      if (pull_phase) begin
        r.pull_drive = 1'b1;
        r.pull_target = regs.pull_travel;
        if (t.pull_speed == 16'sd0) begin
          pull_phase = 1'b0;
          return_phase = 1'b1;
          reload_on = 1'b1;
        end
      end else if (return_phase) begin
        r.pull_drive = 1'b1;
        r.pull_target = '0;
        if (at_spot(t.pull_position, regs.pull_origin, regs.pull_travel)) begin
          pull_phase = 1'b1;
          return_phase = 1'b0;
          launch_due = 1'b0;
        end
      end
    end

    if (reload_on) begin
      if (stages_left[0]) begin
        // single move home
        r.loader_drive = 1'b1;
        r.loader_target = regs.home_position;
        if (at_spot(t.loader_position, regs.loader_origin, regs.home_position)) begin
          stages_left[0] = 1'b0;
          reload_on = 1'b0;
        end
      end else if (stages_left[2:1] != 2'b00) begin
        stage_bit = stages_left[1] ? 3'b010 : 3'b100;
        pick_bit  = stages_left[1] ? 2'b01 : 2'b10;
        pick_pos  = stages_left[1] ? regs.second_pickup_position
                                   : regs.third_pickup_position;
        if ((picked & pick_bit) == 2'b00) begin
          r.loader_drive = 1'b1;
          r.loader_target = pick_pos;
          if (at_spot(t.loader_position, regs.loader_origin, pick_pos))
            picked = picked | pick_bit;
        end else if (hold_cnt < regs.putter_hold_ticks) begin
          // putter down, counter saturates at the hold length
          hold_cnt = hold_cnt + 16'd1;
          r.putter_drive = 1'b1;
          r.putter_up = 1'b0;
        end else begin
          r.loader_drive = 1'b1;
          r.loader_target = regs.home_position;
          r.putter_drive = 1'b1;
          r.putter_up = 1'b1;
          if (at_spot(t.loader_position, regs.loader_origin, regs.home_position)) begin
            stages_left = stages_left & ~stage_bit;
            reload_on = 1'b0;
            hold_cnt = '0;
          end
        end
      end
    end

    r.busy_res = launch_due | reload_on;
    return r;
  endfunction

  task automatic note_fail(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t ns: %s", $time, msg);
  endtask

  // Watch config writes, input beats and result beats
  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst_n) begin
      regs = '0;
      regs.arrive_tolerance = TOLERANCE_RESET;
      launch_due = 1'b0;
      pull_phase = 1'b1;
      return_phase = 1'b0;
      reload_on = 1'b0;
      stages_left = STAGES_ALL;
      picked = '0;
      hold_cnt = '0;
      fail_count = 0;
      results_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_PULL_TRAVEL:   regs.pull_travel = cfg_wdata;
          REG_PULL_ORIGIN:   regs.pull_origin = cfg_wdata;
          REG_LOADER_ORIGIN: regs.loader_origin = cfg_wdata;
          REG_HOME_POS:      regs.home_position = cfg_wdata;
          REG_SECOND_PICK:   regs.second_pickup_position = cfg_wdata;
          REG_THIRD_PICK:    regs.third_pickup_position = cfg_wdata;
          REG_HOLD_TICKS:    regs.putter_hold_ticks = cfg_wdata[15:0];
          REG_TOLERANCE:     regs.arrive_tolerance = cfg_wdata[15:0];
          default: ;
        endcase
      end

      if (in_ch.valid && in_ch.ready)
        results_due.push_back(advance_tick({in_ch.launched, in_ch.pull_position,
                                            in_ch.pull_speed, in_ch.loader_position}));

      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.pull_drive, out_ch.pull_target, out_ch.loader_drive,
               out_ch.loader_target, out_ch.putter_drive, out_ch.putter_up,
               out_ch.busy_res};
        if (results_due.size() == 0) begin
          note_fail("result beat with nothing expected");
        end else begin
          want = results_due.pop_front();
          if (got.pull_drive !== want.pull_drive)
            note_fail($sformatf("pull_drive: expected %0d, got %0d",
                                want.pull_drive, got.pull_drive));
          if (got.pull_target !== want.pull_target)
            note_fail($sformatf("pull_target: expected %0d, got %0d",
                                want.pull_target, got.pull_target));
          if (got.loader_drive !== want.loader_drive)
            note_fail($sformatf("loader_drive: expected %0d, got %0d",
                                want.loader_drive, got.loader_drive));
          if (got.loader_target !== want.loader_target)
            note_fail($sformatf("loader_target: expected %0d, got %0d",
                                want.loader_target, got.loader_target));
          if (got.putter_drive !== want.putter_drive)
            note_fail($sformatf("putter_drive: expected %0d, got %0d",
                                want.putter_drive, got.putter_drive));
          if (got.putter_up !== want.putter_up)
            note_fail($sformatf("putter_up: expected %0d, got %0d",
                                want.putter_up, got.putter_up));
          if (got.busy_res !== want.busy_res)
            note_fail($sformatf("busy_res: expected %0d, got %0d",
                                want.busy_res, got.busy_res));
        end
      end
    end
    outstanding <= results_due.size();
  end

endmodule

[tb/launcher_reload_sequencer_core_tb.sv]
// Testbench top for the launcher reload sequencer: clock, reset, tick stimulus, config phases and verdict.
`timescale 1ns / 1ps

module launcher_reload_sequencer_core_tb;
  import lrs_pkg::*;

  localparam int RUN_LIMIT_NS = 2_400_000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [31:0] cfg_wdata;
  int          fail_count;
  int          outstanding;
  logic        calm;   // no idling on either side while set
  cfg_t        cur;

  lrs_in_if  in_ch();
  lrs_out_if out_ch();

  launcher_reload_sequencer_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  lrs_tick_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic item_t tick(input logic l, input logic signed [31:0] pp,
                                 input logic signed [15:0] sp,
                                 input logic signed [31:0] lp);
    item_t t;
    t.launched = l;
    t.pull_position = pp;
    t.pull_speed = sp;
    t.loader_position = lp;
    return t;
  endfunction

  // Position around a reference, spanning just past the tolerance on both sides
  function automatic logic signed [31:0] near(input longint ref_pos, input int tol);
    longint off;
    off = longint'($urandom_range(0, 2 * tol + 4)) - tol - 2;
    return 32'(ref_pos + off);
  endfunction

  // Mostly plausible ticks (stalls, arrivals) with some pure noise
  function automatic item_t random_tick();
    item_t t;
    longint spot;
    t.launched = ($urandom_range(0, 7) == 0);
    t.pull_position = $urandom;
    t.pull_speed = 16'($urandom);
    t.loader_position = $urandom;
    if ($urandom_range(0, 99) >= 12) begin
      if ($urandom_range(0, 3) == 0) t.pull_speed = '0;
      if ($urandom_range(0, 2) == 0)
        t.pull_position = near(longint'(cur.pull_origin) + longint'(cur.pull_travel),
                               int'(cur.arrive_tolerance));
      if ($urandom_range(0, 14) == 0) begin
        case ($urandom_range(0, 2))
          0:       spot = longint'(cur.home_position);
          1:       spot = longint'(cur.second_pickup_position);
          default: spot = longint'(cur.third_pickup_position);
        endcase
        t.loader_position = near(longint'(cur.loader_origin) + spot,
                                 int'(cur.arrive_tolerance));
      end
    end
    return t;
  endfunction

  task automatic send_tick(input item_t t);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.launched <= t.launched;
    in_ch.pull_position <= t.pull_position;
    in_ch.pull_speed <= t.pull_speed;
    in_ch.loader_position <= t.loader_position;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Stop sending and wait for every predicted beat to come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic load_cfg(input cfg_t c);
    write_reg(REG_PULL_TRAVEL, c.pull_travel);
    write_reg(REG_PULL_ORIGIN, c.pull_origin);
    write_reg(REG_LOADER_ORIGIN, c.loader_origin);
    write_reg(REG_HOME_POS, c.home_position);
    write_reg(REG_SECOND_PICK, c.second_pickup_position);
    write_reg(REG_THIRD_PICK, c.third_pickup_position);
    write_reg(REG_HOLD_TICKS, {16'd0, c.putter_hold_ticks});
    write_reg(REG_TOLERANCE, {16'd0, c.arrive_tolerance});
    cfg_we <= 1'b0;
    cur = c;
  endtask

  // Result side: random stall before each beat
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  // Main sequence: reset, directed ticks, random phases, verdict
  initial begin
    cfg_t c;
    calm = 1'b0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= REG_PULL_TRAVEL;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.launched <= 1'b0;
    in_ch.pull_position <= '0;
    in_ch.pull_speed <= '0;
    in_ch.loader_position <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset config: idle tick at field extremes, then a launch (pull target 0)
    send_tick(tick(1'b0, 32'sh7FFF_FFFF, -16'sd32768, 32'sh8000_0000));
    send_tick(tick(1'b1, -32'sd5, 16'sd7, 32'sd0));
    drain();

    // Pull reference 5100, loader home 100, second 19800, third -30200
    c.pull_travel = 32'sd5000;
    c.pull_origin = 32'sd100;
    c.loader_origin = -32'sd200;
    c.home_position = 32'sd300;
    c.second_pickup_position = 32'sd20000;
    c.third_pickup_position = -32'sd30000;
    c.putter_hold_ticks = 16'd2;
    c.arrive_tolerance = 16'd50;
    load_cfg(c);

    // launch while one is pending, then stall arms reload and stage one runs
    send_tick(tick(1'b1, 32'sd0, -16'sd32768, 32'sd0));
    send_tick(tick(1'b0, 32'sd0, 16'sd0, 32'sd0));
    // pull one past tolerance; loader home exactly at the tolerance edge
    send_tick(tick(1'b0, 32'sd5049, 16'sd32767, 32'sd150));
    send_tick(tick(1'b0, 32'sd5150, 16'sd1, 32'sd0));
    send_tick(tick(1'b0, 32'sd5100, 16'sd0, 32'sd100));
    // launch and stall in one tick: second stage starts the same tick
    send_tick(tick(1'b1, 32'sd0, 16'sd0, 32'sd0));
    send_tick(tick(1'b0, 32'sd5100, 16'sd5, 32'sd19749));
    send_tick(tick(1'b0, 32'sd0, 16'sd5, 32'sd19850));
    // two hold ticks, then home with putter up, then arrival clears the count
    send_tick(tick(1'b0, 32'sd0, 16'sd0, 32'sd0));
    send_tick(tick(1'b0, 32'sd0, 16'sd0, 32'sd0));
    send_tick(tick(1'b0, 32'sd0, 16'sd0, 32'sd0));
    send_tick(tick(1'b0, 32'sd0, 16'sd0, 32'sd50));

    // Random phases, each under its own settings
    for (int p = 0; p < 6; p++) begin
      drain();
      case (p)
        0: begin
          c.pull_travel = 32'($urandom_range(0, 2_000_000)) - 32'sd1_000_000;
          c.pull_origin = 32'($urandom_range(0, 2_000_000)) - 32'sd1_000_000;
          c.loader_origin = 32'($urandom_range(0, 2_000_000)) - 32'sd1_000_000;
          c.home_position = 32'($urandom_range(0, 2_000_000)) - 32'sd1_000_000;
          c.second_pickup_position = 32'($urandom_range(0, 2_000_000)) - 32'sd1_000_000;
          c.third_pickup_position = 32'($urandom_range(0, 2_000_000)) - 32'sd1_000_000;
          c.putter_hold_ticks = 16'($urandom_range(0, 8));
          c.arrive_tolerance = 16'($urandom_range(0, 2000));
        end
        1: begin
          // sums past 32 bits: some references are out of reach
          c.pull_travel = 32'sh7FFF_FFFF;
          c.pull_origin = 32'sh7FFF_FFFF;
          c.loader_origin = 32'sh8000_0000;
          c.home_position = 32'sh7FFF_FFFF;
          c.second_pickup_position = 32'sh8000_0000;
          c.third_pickup_position = 32'sd0;
          c.putter_hold_ticks = 16'd0;
          c.arrive_tolerance = 16'd0;
        end
        2: begin
          c.pull_travel = -32'sd40000;
          c.pull_origin = 32'($urandom_range(0, 100_000));
          c.loader_origin = -32'($urandom_range(0, 100_000));
          c.home_position = 32'sd0;
          c.second_pickup_position = 32'sd150000;
          c.third_pickup_position = -32'sd150000;
          c.putter_hold_ticks = 16'($urandom_range(0, 20));
          c.arrive_tolerance = 16'hFFFF;
        end
        3: begin
          c.pull_travel = $urandom;
          c.pull_origin = $urandom;
          c.loader_origin = $urandom;
          c.home_position = $urandom;
          c.second_pickup_position = $urandom;
          c.third_pickup_position = $urandom;
          c.putter_hold_ticks = 16'($urandom_range(0, 12));
          c.arrive_tolerance = 16'($urandom);
        end
        4: begin
          c.pull_travel = 32'sh8000_0000;
          c.pull_origin = 32'sh7FFF_FFFF;
          c.loader_origin = 32'sd0;
          c.home_position = 32'sh8000_0000;
          c.second_pickup_position = 32'sh7FFF_FFFF;
          c.third_pickup_position = 32'sd12345;
          c.putter_hold_ticks = 16'd1;
          c.arrive_tolerance = 16'($urandom_range(0, 300));
        end
        default: begin
          c.pull_travel = 32'($urandom_range(0, 60000));
          c.pull_origin = -32'sd7;
          c.loader_origin = 32'sd7;
          c.home_position = 32'sd0;
          c.second_pickup_position = 32'sd5000;
          c.third_pickup_position = 32'sd10000;
          c.putter_hold_ticks = 16'hFFFF;
          c.arrive_tolerance = 16'($urandom_range(0, 500));
        end
      endcase
      load_cfg(c);
      calm = (p == 1 || p == 4);
      repeat (115) send_tick(random_tick());
    end

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Hard stop if the handshakes hang
  initial begin
    #(RUN_LIMIT_NS);
    $display("== FAIL ==");
    $finish;
  end

endmodule
